// ===== hw/rtl/hpack_huffman_decoder_macros.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef HPACK_HUFFMAN_DECODER_MACROS_SVH
`define HPACK_HUFFMAN_DECODER_MACROS_SVH

// Same-cycle implication, gated off while reset is held.
`define HPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off while reset is held.
`define HPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hpd_pkg.sv =====
package hpd_pkg;

    localparam int LONGEST_CODE = 30;
    localparam int SYMBOL_COUNT = 257;
    localparam int EOS_SYMBOL   = 256;
    localparam int PAD_LIMIT    = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = 1;
    localparam int QUEUE_CNT_W  = 2;

    typedef enum logic [2:0] {
        KIND_SYMBOL = 3'd0,
        KIND_DONE   = 3'd1,
        KIND_EOS    = 3'd2,
        KIND_LIMIT  = 3'd3,
        KIND_PAD    = 3'd4
    } kind_t;

    // first error seen in the current string
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_EOS   = 2'd1,
        ERR_LIMIT = 2'd2
    } err_t;

    typedef struct packed {
        logic [7:0] coded_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  decoded_byte;
        kind_t       kind;
        logic [15:0] decoded_count;
        logic        last_of_run;
    } result_t;

    // number of codes of each length, canonical order
    localparam logic [5:0] LEN_COUNT [0:LONGEST_CODE] = '{
        6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd10, 6'd26, 6'd32, 6'd6, 6'd0, 6'd5,
        6'd3, 6'd2, 6'd6, 6'd2, 6'd3, 6'd0, 6'd0, 6'd0, 6'd3, 6'd8, 6'd13,
        6'd26, 6'd29, 6'd12, 6'd4, 6'd15, 6'd19, 6'd29, 6'd0, 6'd4};

    // symbols in canonical rank order
    localparam logic [8:0] SYM_ROM [0:SYMBOL_COUNT-1] = '{
        9'd48, 9'd49, 9'd50, 9'd97, 9'd99, 9'd101, 9'd105, 9'd111, 9'd115, 9'd116,
        9'd32, 9'd37, 9'd45, 9'd46, 9'd47, 9'd51, 9'd52, 9'd53, 9'd54, 9'd55,
        9'd56, 9'd57, 9'd61, 9'd65, 9'd95, 9'd98, 9'd100, 9'd102, 9'd103, 9'd104,
        9'd108, 9'd109, 9'd110, 9'd112, 9'd114, 9'd117, 9'd58, 9'd66, 9'd67, 9'd68,
        9'd69, 9'd70, 9'd71, 9'd72, 9'd73, 9'd74, 9'd75, 9'd76, 9'd77, 9'd78,
        9'd79, 9'd80, 9'd81, 9'd82, 9'd83, 9'd84, 9'd85, 9'd86, 9'd87, 9'd89,
        9'd106, 9'd107, 9'd113, 9'd118, 9'd119, 9'd120, 9'd121, 9'd122, 9'd38, 9'd42,
        9'd44, 9'd59, 9'd88, 9'd90, 9'd33, 9'd34, 9'd40, 9'd41, 9'd63, 9'd39,
        9'd43, 9'd124, 9'd35, 9'd62, 9'd0, 9'd36, 9'd64, 9'd91, 9'd93, 9'd126,
        9'd94, 9'd125, 9'd60, 9'd96, 9'd123, 9'd92, 9'd195, 9'd208, 9'd128, 9'd130,
        9'd131, 9'd162, 9'd184, 9'd194, 9'd224, 9'd226, 9'd153, 9'd161, 9'd167, 9'd172,
        9'd176, 9'd177, 9'd179, 9'd209, 9'd216, 9'd217, 9'd227, 9'd229, 9'd230, 9'd129,
        9'd132, 9'd133, 9'd134, 9'd136, 9'd146, 9'd154, 9'd156, 9'd160, 9'd163, 9'd164,
        9'd169, 9'd170, 9'd173, 9'd178, 9'd181, 9'd185, 9'd186, 9'd187, 9'd189, 9'd190,
        9'd196, 9'd198, 9'd228, 9'd232, 9'd233, 9'd1, 9'd135, 9'd137, 9'd138, 9'd139,
        9'd140, 9'd141, 9'd143, 9'd147, 9'd149, 9'd150, 9'd151, 9'd152, 9'd155, 9'd157,
        9'd158, 9'd165, 9'd166, 9'd168, 9'd174, 9'd175, 9'd180, 9'd182, 9'd183, 9'd188,
        9'd191, 9'd197, 9'd231, 9'd239, 9'd9, 9'd142, 9'd144, 9'd145, 9'd148, 9'd159,
        9'd171, 9'd206, 9'd215, 9'd225, 9'd236, 9'd237, 9'd199, 9'd207, 9'd234, 9'd235,
        9'd192, 9'd193, 9'd200, 9'd201, 9'd202, 9'd205, 9'd210, 9'd213, 9'd218, 9'd219,
        9'd238, 9'd240, 9'd242, 9'd243, 9'd255, 9'd203, 9'd204, 9'd211, 9'd212, 9'd214,
        9'd221, 9'd222, 9'd223, 9'd241, 9'd244, 9'd245, 9'd246, 9'd247, 9'd248, 9'd250,
        9'd251, 9'd252, 9'd253, 9'd254, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7,
        9'd8, 9'd11, 9'd12, 9'd14, 9'd15, 9'd16, 9'd17, 9'd18, 9'd19, 9'd20,
        9'd21, 9'd23, 9'd24, 9'd25, 9'd26, 9'd27, 9'd28, 9'd29, 9'd30, 9'd31,
        9'd127, 9'd220, 9'd249, 9'd10, 9'd13, 9'd22, 9'd256};

endpackage

// ===== hw/rtl/hpd_front.sv =====
`include "hpack_huffman_decoder_macros.svh"

module hpd_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hpd_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_pop,
    output hpd_pkg::item_t q_item
);
    import hpd_pkg::*;

    item_t                  entry_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   push;
    logic                   pop;

    assign in_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `HPD_ASSERT_NOW(a_q_bound, aclk, aresetn, 1'b1,
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue occupancy above depth")
    `HPD_ASSERT_NOW(a_q_pop_empty, aclk, aresetn, q_pop, q_valid,
        "back end pops an empty queue")
    `HPD_ASSERT_NEXT(a_q_grow, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count missed a push")

endmodule

// ===== hw/rtl/hpd_back.sv =====
`include "hpack_huffman_decoder_macros.svh"

module hpd_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [15:0]      max_output_bytes,
    input  logic             q_valid,
    output logic             q_pop,
    input  hpd_pkg::item_t   q_item,
    output logic             out_valid,
    input  logic             out_ready,
    output hpd_pkg::result_t out_result
);
    import hpd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BITS,
        BK_STATUS
    } bk_state_t;

    bk_state_t              state_reg, state_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic [2:0]             bit_idx_reg, bit_idx_next;
    logic [29:0]            partial_reg, partial_next;
    logic [30:0]            first_reg, first_next;
    logic [8:0]             rank_reg, rank_next;
    logic [4:0]             bic_reg, bic_next;
    logic                   ones_reg, ones_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    err_t                   err_reg, err_next;
    logic                   held_valid_reg, held_valid_next;
    result_t                held_reg, held_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic                   bit_val;
    logic [4:0]             bic_inc;
    logic [29:0]            pc_or;
    logic [5:0]             cnt;
    logic [31:0]            diff;
    logic                   match;
    logic [9:0]             at;
    logic [8:0]             sym;
    logic                   is_eos;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       count_inc_ext;
    logic [CMP_W-1:0]       max_ext;
    logic                   limit_hit;
    logic                   active;
    logic                   produce;
    logic                   out_free;
    logic                   stall;
    logic                   step_fire;
    logic                   status_fire;
    logic                   last_bit;
    logic                   out_load;
    logic [30:0]            first_sum;
    kind_t                  status_kind;
    result_t                sym_result;
    result_t                status_result;

    // one code bit per cycle through the canonical tables, unless stalled on output
    always_comb begin
        bit_val   = byte_reg[bit_idx_reg];
        bic_inc   = bic_reg + 5'd1;
        pc_or     = {partial_reg[29:1], partial_reg[0] | bit_val};
        cnt       = LEN_COUNT[(bic_inc <= 5'(LONGEST_CODE)) ? bic_inc : 5'd0];
        diff      = {2'b00, pc_or} - {1'b0, first_reg};
        match     = diff < {26'd0, cnt};
        at        = {1'b0, rank_reg} + {4'd0, diff[5:0]};
        sym       = (at < 10'(SYMBOL_COUNT)) ? SYM_ROM[at[8:0]] : 9'(EOS_SYMBOL);
        is_eos    = (sym == 9'(EOS_SYMBOL));
        first_sum = first_reg + {25'd0, cnt};
    end

    assign count_inc     = count_reg + 1'b1;
    assign count_ext     = CMP_W'(count_reg);
    assign count_inc_ext = CMP_W'(count_inc);
    assign max_ext       = CMP_W'(max_output_bytes);
    assign limit_hit     = (count_ext >= max_ext) || (count_reg == '1);

    assign active      = (state_reg == BK_BITS) && (err_reg == ERR_NONE);
    assign produce     = active && match && !is_eos && !limit_hit;
    assign out_free    = !out_valid_reg || out_ready;
    assign stall       = produce && held_valid_reg && !out_free;
    assign step_fire   = (state_reg == BK_BITS) && !stall;
    assign status_fire = (state_reg == BK_STATUS) && !(held_valid_reg && !out_free);
    assign last_bit    = (bit_idx_reg == 3'd0);

    // held result leaves when sealed, or when a newer result displaces it
    assign out_load = held_valid_reg && out_free &&
                      (held_reg.last_of_run || (step_fire && produce) || status_fire);

    always_comb begin
        case (err_reg)
            ERR_EOS:   status_kind = KIND_EOS;
            ERR_LIMIT: status_kind = KIND_LIMIT;
            default: begin
                if ((bic_reg != 5'd0) && !(ones_reg && (bic_reg < 5'(PAD_LIMIT)))) begin
                    status_kind = KIND_PAD;
                end else begin
                    status_kind = KIND_DONE;
                end
            end
        endcase
    end

    always_comb begin
        sym_result.decoded_byte  = sym[7:0];
        sym_result.kind          = KIND_SYMBOL;
        sym_result.decoded_count = count_inc_ext[15:0];
        sym_result.last_of_run   = last_bit && !last_reg;

        status_result.decoded_byte  = 8'd0;
        status_result.kind          = status_kind;
        status_result.decoded_count = count_ext[15:0];
        status_result.last_of_run   = 1'b1;
    end

    always_comb begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        bit_idx_next    = bit_idx_reg;
        partial_next    = partial_reg;
        first_next      = first_reg;
        rank_next       = rank_reg;
        bic_next        = bic_reg;
        ones_next       = ones_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        q_pop           = 1'b0;

        if (out_load) begin
            out_valid_next  = 1'b1;
            out_next        = held_reg;
            held_valid_next = 1'b0;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop        = 1'b1;
                    byte_next    = q_item.coded_byte;
                    last_next    = q_item.last_byte;
                    bit_idx_next = 3'd7;
                    state_next   = BK_BITS;
                end
            end
            BK_BITS: begin
                if (step_fire) begin
                    if (active) begin
                        if (match || (bic_inc >= 5'(LONGEST_CODE))) begin
                            partial_next = '0;
                            first_next   = '0;
                            rank_next    = '0;
                            bic_next     = '0;
                            ones_next    = 1'b1;
                            if (!match || is_eos) begin
                                err_next = ERR_EOS;
                            end else if (limit_hit) begin
                                err_next = ERR_LIMIT;
                            end else begin
                                count_next = count_inc;
                            end
                        end else begin
                            rank_next    = rank_reg + {3'd0, cnt};
                            first_next   = {first_sum[29:0], 1'b0};
                            partial_next = {pc_or[28:0], 1'b0};
                            bic_next     = bic_inc;
                            ones_next    = ones_reg && bit_val;
                        end
                    end
                    if (produce) begin
                        held_valid_next = 1'b1;
                        held_next       = sym_result;
                    end else if (last_bit && !last_reg && held_valid_reg) begin
                        held_next.last_of_run = 1'b1;
                    end
                    if (!last_bit) begin
                        bit_idx_next = bit_idx_reg - 3'd1;
                    end else if (last_reg) begin
                        state_next = BK_STATUS;
                    end else if (q_valid) begin
                        q_pop        = 1'b1;
                        byte_next    = q_item.coded_byte;
                        last_next    = q_item.last_byte;
                        bit_idx_next = 3'd7;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_STATUS: begin
                if (status_fire) begin
                    held_valid_next = 1'b1;
                    held_next       = status_result;
                    partial_next    = '0;
                    first_next      = '0;
                    rank_next       = '0;
                    bic_next        = '0;
                    ones_next       = 1'b1;
                    count_next      = '0;
                    err_next        = ERR_NONE;
                    if (q_valid) begin
                        q_pop        = 1'b1;
                        byte_next    = q_item.coded_byte;
                        last_next    = q_item.last_byte;
                        bit_idx_next = 3'd7;
                        state_next   = BK_BITS;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            partial_reg    <= '0;
            first_reg      <= '0;
            rank_reg       <= '0;
            bic_reg        <= '0;
            ones_reg       <= 1'b1;
            count_reg      <= '0;
            err_reg        <= ERR_NONE;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            partial_reg    <= partial_next;
            first_reg      <= first_next;
            rank_reg       <= rank_next;
            bic_reg        <= bic_next;
            ones_reg       <= ones_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        bit_idx_reg <= bit_idx_next;
        held_reg    <= held_next;
        out_reg     <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    `HPD_ASSERT_NOW(a_status_closes, aclk, aresetn,
        out_load && (held_reg.kind != KIND_SYMBOL), held_reg.last_of_run,
        "status result not marked last of run")
    `HPD_ASSERT_NOW(a_code_len, aclk, aresetn, 1'b1, bic_reg < 5'(LONGEST_CODE),
        "partial code length out of range")
    `HPD_ASSERT_NOW(a_status_last, aclk, aresetn, state_reg == BK_STATUS, last_reg,
        "status phase entered on a byte not marked last")
    `HPD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, (state_reg == BK_BITS) && stall,
        (state_reg == BK_BITS) && $stable(bit_idx_reg) && $stable(partial_reg),
        "decoder advanced while stalled on output")

endmodule

// ===== hw/rtl/hpack_huffman_decoder.sv =====
// Channel   Dir  Payload                                   Transfer
// s_        in   tdata[7:0]=coded_byte, tlast=last_byte    s_tvalid & s_tready
// m_        out  tdata[7:0]=decoded_byte,                  m_tvalid & m_tready
//                tdata[23:8]=decoded_count,
//                tuser[2:0]=result_kind, tlast=last_of_run
// cfg_      in   cfg_data[15:0]=max_output_bytes           cfg_valid & cfg_ready
//
// Decode: one code bit per cycle through the canonical length/symbol tables
// unless stalled on output; a byte marked last adds a status step.
// A two-entry input queue lets the next transfers land while a byte decodes.
// Reset: aresetn synchronous, active low; limit register resets to 4096.
// Stalls: decoding halts only when a new symbol meets a full output register
// and a full hold slot; status results likewise wait for output space.

module hpack_huffman_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] coded_byte
    input  logic        s_tlast,    // last_byte
    // decoded results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] decoded_byte, [23:8] decoded_count
    output logic [2:0]  m_tuser,    // [2:0] result_kind
    output logic        m_tlast,    // last_of_run
    // limit register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // max_output_bytes
);
    import hpd_pkg::*;

    logic [15:0] max_bytes_reg;
    item_t       in_item;
    item_t       q_item;
    logic        q_valid;
    logic        q_pop;
    result_t     result;

    // register write always taken; new limit applies on the next bit step
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= 16'd4096;
        end else if (cfg_valid && cfg_ready) begin
            max_bytes_reg <= cfg_data;
        end
    end

    assign in_item.coded_byte = s_tdata;
    assign in_item.last_byte  = s_tlast;

    // front: input queue
    hpd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // back: bit-serial canonical decode, hold slot and output register
    hpd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .max_output_bytes (max_bytes_reg),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_result       (result)
    );

    assign m_tdata = {result.decoded_count, result.decoded_byte};
    assign m_tuser = result.kind;
    assign m_tlast = result.last_of_run;

endmodule

// ===== tb/tb_hpack_huffman_decoder.sv =====
module tb_hpack_huffman_decoder;
    import hpd_pkg::*;

    // Longest legal quiet stretch is the receiver hold-off (RECV_HOLD) plus
    // decode passes, so reaching STALL_LIMIT with no transfer anywhere means a hang.
    localparam int STALL_LIMIT   = 3000;
    // Up to two queued bytes plus one in flight can still be decoding after
    // the last result shows up; SETTLE_CYCLES leaves room for them.
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int RECV_HOLD     = 400;

    // how a test string is closed off
    typedef enum int {
        PAD_ONES,   // legal: ones up to the byte boundary
        PAD_ZEROS,  // at least one zero, then zeros up to the byte boundary
        PAD_LONG    // ones to the boundary plus one more full byte of ones
    } pad_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = 16'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;   // [7:0] decoded_byte, [23:8] decoded_count
    logic [2:0]  m_tuser;   // [2:0] result_kind
    logic        m_tlast;   // last_of_run
    logic        cfg_ready;

    always #5 aclk = ~aclk;

    hpack_huffman_decoder #(
        .COUNT_WIDTH(16)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Decoder state as predicted by the testbench
    // ------------------------------------------------------------------
    logic [29:0] dec_partial;   // code bits gathered so far
    logic [30:0] dec_first;     // first canonical code at the current length
    logic [8:0]  dec_rank;      // rank of that first code
    logic [4:0]  dec_nbits;     // length of the unfinished code
    logic        dec_ones;      // unfinished code is all ones so far
    logic [15:0] dec_count;     // symbols emitted in this string
    err_t        dec_err;
    logic [15:0] dec_limit;     // max_output_bytes shadow

    result_t expected_results[$];
    int      mismatch_count = 0;
    int      src_idle_pct   = 0;
    int      sink_idle_pct  = 0;
    int      sink_hold      = 0;
    int      quiet_cycles   = 0;
    int      items_sent     = 0;

    // canonical code of each rank, used to build legal coded strings
    logic [29:0] code_of [0:SYMBOL_COUNT-1];
    int          len_of  [0:SYMBOL_COUNT-1];
    int          sym_ranks[$];
    logic [7:0]  coded_q[$];

    function automatic void restart_code();
        dec_partial = '0;
        dec_first   = '0;
        dec_rank    = '0;
        dec_nbits   = '0;
        dec_ones    = 1'b1;
    endfunction

    // Walk one coded byte MSB first and queue the results it must produce.
    function automatic void huff_decode_step(input logic [7:0] cb, input logic lb);
        result_t     outs[$];
        result_t     r;
        logic [31:0] cnt;
        logic [31:0] diff;
        logic [31:0] at;
        logic [8:0]  sym;
        kind_t       kind;
        for (int i = 7; i >= 0 && dec_err == ERR_NONE; i--) begin
            dec_nbits   = dec_nbits + 5'd1;
            dec_ones    = dec_ones & cb[i];
            dec_partial = dec_partial | 30'(cb[i]);
            cnt  = (dec_nbits <= LONGEST_CODE) ? 32'(LEN_COUNT[dec_nbits]) : 32'd0;
            diff = 32'(dec_partial) - 32'(dec_first);
            if (diff < cnt) begin
                at  = 32'(dec_rank) + diff;
                sym = (at < SYMBOL_COUNT) ? SYM_ROM[at] : 9'(EOS_SYMBOL);
                restart_code();
                if (sym == 9'(EOS_SYMBOL)) begin
                    dec_err = ERR_EOS;
                end else if (dec_count >= dec_limit || dec_count == 16'hFFFF) begin
                    // symbol that would overrun the limit is dropped
                    dec_err = ERR_LIMIT;
                end else if (outs.size() < 3) begin
                    dec_count = dec_count + 16'd1;
                    r = '{sym[7:0], KIND_SYMBOL, dec_count, 1'b0};
                    outs.insert(outs.size(), r);
                end
            end else if (dec_nbits >= LONGEST_CODE) begin
                restart_code();
                dec_err = ERR_EOS;
            end else begin
                dec_rank    = dec_rank + 9'(cnt);
                dec_first   = 31'((32'(dec_first) + cnt) << 1);
                dec_partial = dec_partial << 1;
            end
        end
        if (lb) begin
            if (dec_err == ERR_EOS)
                kind = KIND_EOS;
            else if (dec_err == ERR_LIMIT)
                kind = KIND_LIMIT;
            else if (dec_nbits != 0 && !(dec_ones && dec_nbits < PAD_LIMIT))
                kind = KIND_PAD;
            else
                kind = KIND_DONE;
            if (outs.size() < 3) begin
                r = '{8'd0, kind, dec_count, 1'b0};
                outs.insert(outs.size(), r);
            end
            restart_code();
            dec_count = '0;
            dec_err   = ERR_NONE;
        end
        for (int k = 0; k < outs.size(); k++) begin
            r = outs[k];
            r.last_of_run = (k == outs.size() - 1);
            expected_results.insert(expected_results.size(), r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random ready, optional long hold-off, in-order check
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: byte %02h kind %0d count %0d last %b",
                             m_tdata[7:0], m_tuser, m_tdata[23:8], m_tlast);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[7:0] !== want.decoded_byte || m_tdata[23:8] !== want.decoded_count
                        || m_tuser !== want.kind || m_tlast !== want.last_of_run) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display({"wrong result: want byte %02h kind %0d count %0d last %b,",
                                  " got byte %02h kind %0d count %0d last %b"},
                                 want.decoded_byte, want.kind, want.decoded_count,
                                 want.last_of_run, m_tdata[7:0], m_tuser, m_tdata[23:8],
                                 m_tlast);
                    mismatch_count++;
                end
            end
        end
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("hpack_huffman_decoder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transfer. valid is only dropped when the sender idles, so a
    // back-to-back transfer never sees two writes in one time step.
    task automatic send_coded_byte(input logic [7:0] cb, input logic lb);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cb;
        s_tlast  <= lb;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        huff_decode_step(cb, lb);
        items_sent++;
    endtask

    // Drain: all results back, then room for bytes that yield nothing.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        dec_limit = value;
    endtask

    // Pack the codes of sym_ranks MSB first into coded_q, then close it off.
    function automatic void encode_string(input pad_t pad);
        bit         bits[$];
        logic [7:0] b;
        coded_q.delete();
        foreach (sym_ranks[k])
            for (int j = len_of[sym_ranks[k]] - 1; j >= 0; j--)
                bits.insert(bits.size(), code_of[sym_ranks[k]][j]);
        case (pad)
            PAD_ONES: begin
                while (bits.size() % 8 != 0) bits.insert(bits.size(), 1'b1);
            end
            PAD_ZEROS: begin
                do bits.insert(bits.size(), 1'b0); while (bits.size() % 8 != 0);
            end
            default: begin
                while (bits.size() % 8 != 0) bits.insert(bits.size(), 1'b1);
                repeat (8) bits.insert(bits.size(), 1'b1);
            end
        endcase
        for (int k = 0; k < bits.size(); k += 8) begin
            for (int j = 0; j < 8; j++)
                b[7 - j] = bits[k + j];
            coded_q.insert(coded_q.size(), b);
        end
    endfunction

    task automatic send_string(input pad_t pad);
        encode_string(pad);
        foreach (coded_q[k])
            send_coded_byte(coded_q[k], k == coded_q.size() - 1);
    endtask

    // Mostly short codes, some from the whole table, rare EOS or bad padding.
    task automatic send_random_string();
        int n;
        int roll;
        sym_ranks.delete();
        n = $urandom_range(1, 6);
        repeat (n) begin
            roll = $urandom_range(99);
            sym_ranks.insert(sym_ranks.size(),
                             roll < 70 ? $urandom_range(0, 67) : $urandom_range(0, 255));
        end
        roll = $urandom_range(99);
        if (roll < 6)
            sym_ranks.insert($urandom_range(0, sym_ranks.size()), EOS_SYMBOL);
        if (roll < 82)
            send_string(PAD_ONES);
        else if (roll < 91)
            send_string(PAD_ZEROS);
        else
            send_string(PAD_LONG);
    endtask

    // Raw bytes; the burst always ends a string so the next one starts clean.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
            send_coded_byte(8'($urandom), (k == n - 1) || ($urandom_range(0, 3) == 0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_strings();
        sym_ranks = '{0};
        send_string(PAD_ONES);
        sym_ranks = '{0, 1, 2};
        send_string(PAD_ONES);
        sym_ranks = '{68};                      // 8-bit code, no padding at all
        send_string(PAD_ONES);
        sym_ranks = '{255};                     // longest code, 30 bits
        send_string(PAD_ONES);
        sym_ranks = '{3, EOS_SYMBOL, 4};        // EOS, then bits that are ignored
        send_string(PAD_ONES);
        sym_ranks = '{5};
        send_string(PAD_ZEROS);                 // padding not all ones
        sym_ranks = '{5};
        send_string(PAD_LONG);                  // padding of eight ones or more
        send_coded_byte(8'h00, 1'b1);
        send_coded_byte(8'hFF, 1'b1);
    endtask

    task automatic test_output_limit();
        write_limit(16'd0);                     // first symbol already over
        sym_ranks = '{0};
        send_string(PAD_ONES);
        write_limit(16'd2);
        sym_ranks = '{0, 1, 2, 3, 4};
        send_string(PAD_ONES);
        // Lower the limit halfway through a string: applies right away.
        write_limit(16'hFFFF);
        sym_ranks = '{0, 1, 2, 3, 4, 5};
        encode_string(PAD_ONES);
        send_coded_byte(coded_q[0], 1'b0);
        send_coded_byte(coded_q[1], 1'b0);
        write_limit(16'd3);
        send_coded_byte(coded_q[2], 1'b0);
        send_coded_byte(coded_q[3], 1'b1);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input logic [15:0] limit, input int n_items);
        int start;
        write_limit(limit);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(99) < 85)
                send_random_string();
            else
                send_noise();
        end
    endtask

    // Receiver stops for a long stretch while bytes keep coming.
    task automatic test_backpressure();
        wait_until_idle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_hold     = RECV_HOLD;
        repeat (6) begin
            sym_ranks = '{$urandom_range(0, 9), $urandom_range(0, 9),
                          $urandom_range(0, 9), $urandom_range(0, 9)};
            send_string(PAD_ONES);
        end
    endtask

    initial begin
        int code;
        int rank;
        // canonical code: each length starts at (previous start + count) << 1
        code = 0;
        rank = 0;
        for (int l = 1; l <= LONGEST_CODE; l++) begin
            for (int j = 0; j < LEN_COUNT[l]; j++) begin
                code_of[rank] = 30'(code);
                len_of[rank]  = l;
                code++;
                rank++;
            end
            code = code << 1;
        end
        restart_code();
        dec_count = '0;
        dec_err   = ERR_NONE;
        dec_limit = 16'd4096;

        src_idle_pct  = 28;
        sink_idle_pct = 58;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_strings();
        test_output_limit();
        test_random_traffic(28, 58, 16'($urandom_range(1, 6)), 52);
        test_random_traffic(58, 28, 16'($urandom_range(0, 65535)), 52);
        test_random_traffic(0, 0, 16'd4096, 52);
        test_backpressure();
        wait_until_idle();

        if (mismatch_count == 0)
            $display("hpack_huffman_decoder: match");
        else
            $display("hpack_huffman_decoder: mismatch");
        $finish;
    end

endmodule

// ===== hpack_huffman_decoder.f =====
+incdir+hw/rtl
hw/rtl/hpd_pkg.sv
hw/rtl/hpd_front.sv
hw/rtl/hpd_back.sv
hw/rtl/hpack_huffman_decoder.sv
tb/tb_hpack_huffman_decoder.sv
